### rtl/mbr_pkg.sv
// shared types and constants of the msb-first bit reader
package mbr_pkg;

    localparam int BUF_BYTES      = 256;
    localparam int MAX_READ_BYTES = 8;
    localparam int MAX_READ_BITS  = MAX_READ_BYTES * 8;
    localparam int ADDR_W         = $clog2(BUF_BYTES);
    // bit offsets must hold 8 * BUF_BYTES itself
    localparam int BITS_W         = ADDR_W + 4;
    // width of an availability check: offset plus up to 511 bytes of skip
    localparam int CHK_W          = ((BITS_W > 12) ? BITS_W : 12) + 1;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        REQ_LOAD = 3'd0,
        REQ_BITS = 3'd1,
        REQ_FLAG = 3'd2,
        REQ_SKIP = 3'd3,
        REQ_COMP = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOBITS = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADLEN = 2'd3
    } t_status;

    // command classes handed from the front to the back
    typedef enum logic [2:0] {
        OP_IMM  = 3'd0,
        OP_LOAD = 3'd1,
        OP_READ = 3'd2,
        OP_FLAG = 3'd3,
        OP_SKIP = 3'd4,
        OP_COMP = 3'd5
    } t_op;

    typedef struct packed {
        t_op        op;
        t_status    status;
        logic [7:0] data_byte;
        logic [6:0] bit_count;
        logic       align_right;
        logic [8:0] byte_count;
    } t_cmd;

    typedef struct packed {
        t_status    status;
        logic [7:0] out_byte;
        logic [2:0] byte_index;
        logic       flag_value;
        logic       last;
    } t_result;

endpackage

### rtl/mbr_ram.sv
// generic single-write, dual-read ram with registered read data
module mbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### rtl/mbr_front.sv
// request front end: accepts requests and classifies them into commands
module mbr_front import mbr_pkg::*; (
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_req_type,
    input  logic [7:0] i_data_byte,
    input  logic [6:0] i_bit_count,
    input  logic       i_align_right,
    input  logic [8:0] i_byte_count,
    input  logic       i_queue_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_req req;

    assign req     = t_req'(i_req_type);
    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    always_comb begin
        o_cmd             = '0;
        o_cmd.data_byte   = i_data_byte;
        o_cmd.bit_count   = i_bit_count;
        o_cmd.align_right = i_align_right;
        o_cmd.byte_count  = i_byte_count;
        o_cmd.status      = ST_OK;
        o_cmd.op          = OP_IMM;
        case (req)
            REQ_LOAD: begin
                o_cmd.op = OP_LOAD;
            end
            REQ_BITS: begin
                if (i_bit_count > 7'(MAX_READ_BITS)) begin
                    o_cmd.status = ST_BADLEN;
                end else if (i_bit_count != 7'd0) begin
                    o_cmd.op = OP_READ;
                end
            end
            REQ_FLAG: begin
                o_cmd.op = OP_FLAG;
            end
            REQ_SKIP: begin
                o_cmd.op = OP_SKIP;
            end
            REQ_COMP: begin
                if (i_byte_count == 9'd0 || i_byte_count > 9'(MAX_READ_BYTES)) begin
                    o_cmd.status = ST_BADLEN;
                end else begin
                    o_cmd.op = OP_COMP;
                end
            end
            default: begin
                // unknown request: single ok result
                o_cmd.op = OP_IMM;
            end
        endcase
    end

endmodule

### rtl/mbr_cmd_queue.sv
// short command queue between the front end and the execution back end
module mbr_cmd_queue import mbr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

### rtl/mbr_back.sv
// execution back end: byte buffer, bit offset and result register
module mbr_back import mbr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_cmd    i_q_cmd,
    output logic    o_q_pop,
    output logic    o_m_valid,
    input  logic    i_m_ready,
    output t_result o_m_res
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FLAG  = 7'b0000010,
        S_RD    = 7'b0000100,
        S_ZERO  = 7'b0001000,
        S_CCHK  = 7'b0010000,
        S_CFLAG = 7'b0100000,
        S_ERR   = 7'b1000000
    } t_bstate;

    t_bstate           r_state, n_state;
    logic [BITS_W-1:0] r_off, n_off;
    logic [BITS_W-1:0] r_size, n_size;
    logic [6:0]        r_nbits, n_nbits;
    logic              r_right, n_right;
    logic [2:0]        r_idx, n_idx;
    logic [2:0]        r_last_idx, n_last_idx;
    logic [2:0]        r_cur, n_cur;
    logic              r_out_valid;
    t_result           r_out;

    logic              out_free;
    logic              emit;
    t_result           emit_res;
    logic              ram_we;
    logic              ram_re;
    logic [BITS_W-1:0] fetch_off;
    logic [ADDR_W-1:0] raddr_a;
    logic [7:0]        rd_a, rd_b;
    logic [15:0]       shifted;
    logic [7:0]        top;
    logic [3:0]        nn;
    logic [3:0]        rsh;
    logic [7:0]        bval;
    logic [BITS_W-1:0] off1;
    logic [CHK_W-1:0]  skip_n;
    logic [3:0]        cur_p1;
    logic [6:0]        raw_bits;
    logic [6:0]        nib_bits;
    logic [6:0]        bits_m1;

    function automatic logic have_bits(input logic [BITS_W-1:0] off,
                                       input logic [BITS_W-1:0] size,
                                       input logic [CHK_W-1:0]  n);
        logic [CHK_W-1:0] need;
        need = CHK_W'(off) + n;
        return need <= CHK_W'(size);
    endfunction

    assign raddr_a = fetch_off[ADDR_W+2:3];

    mbr_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_buf (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (r_size[ADDR_W+2:3]),
        .i_wdata   (i_q_cmd.data_byte),
        .i_re      (ram_re),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_a + ADDR_W'(1)),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // bit window starting at the current offset
    assign shifted  = {rd_a, rd_b} << r_off[2:0];
    assign top      = shifted[15:8];
    assign nn       = (r_nbits > 7'd8) ? 4'd8 : r_nbits[3:0];
    assign rsh      = 4'd8 - nn;
    assign bval     = r_right ? (top >> rsh) : (top & ~(8'hFF >> nn));
    assign off1     = r_off + BITS_W'(1);
    assign skip_n   = CHK_W'({i_q_cmd.byte_count, 3'b000});
    assign cur_p1   = {1'b0, r_cur} + 4'd1;
    assign raw_bits = {cur_p1, 3'b000};
    assign nib_bits = shifted[15] ? 7'd4 : 7'd8;
    assign bits_m1  = i_q_cmd.bit_count - 7'd1;

    assign out_free = !r_out_valid || i_m_ready;

    always_comb begin
        n_state    = r_state;
        n_off      = r_off;
        n_size     = r_size;
        n_nbits    = r_nbits;
        n_right    = r_right;
        n_idx      = r_idx;
        n_last_idx = r_last_idx;
        n_cur      = r_cur;
        o_q_pop    = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        fetch_off  = r_off;
        emit       = 1'b0;
        emit_res   = '0;
        emit_res.status = ST_OK;
        emit_res.last   = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_q_pop = 1'b1;
                    case (i_q_cmd.op)
                        OP_IMM: begin
                            emit            = 1'b1;
                            emit_res.status = i_q_cmd.status;
                        end
                        OP_LOAD: begin
                            emit = 1'b1;
                            if (r_size[ADDR_W+3]) begin
                                emit_res.status = ST_FULL;
                            end else begin
                                ram_we = 1'b1;
                                n_size = r_size + BITS_W'(8);
                            end
                        end
                        OP_SKIP: begin
                            emit = 1'b1;
                            if (have_bits(r_off, r_size, skip_n)) begin
                                n_off = r_off + skip_n[BITS_W-1:0];
                            end else begin
                                emit_res.status = ST_NOBITS;
                            end
                        end
                        OP_FLAG: begin
                            if (have_bits(r_off, r_size, CHK_W'(1))) begin
                                ram_re  = 1'b1;
                                n_state = S_FLAG;
                            end else begin
                                emit            = 1'b1;
                                emit_res.status = ST_NOBITS;
                            end
                        end
                        OP_READ: begin
                            if (have_bits(r_off, r_size, CHK_W'(i_q_cmd.bit_count))) begin
                                ram_re     = 1'b1;
                                n_nbits    = i_q_cmd.bit_count;
                                n_right    = i_q_cmd.align_right;
                                n_idx      = 3'd0;
                                n_last_idx = bits_m1[5:3];
                                n_state    = S_RD;
                            end else begin
                                emit            = 1'b1;
                                emit_res.status = ST_NOBITS;
                            end
                        end
                        OP_COMP: begin
                            n_cur      = 3'(i_q_cmd.byte_count[3:0] - 4'd1);
                            n_last_idx = 3'(i_q_cmd.byte_count[3:0] - 4'd1);
                            n_state    = S_CCHK;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_FLAG: begin
                if (out_free) begin
                    emit                = 1'b1;
                    emit_res.flag_value = shifted[15];
                    n_off               = off1;
                    n_state             = S_IDLE;
                end
            end
            S_RD: begin
                if (out_free) begin
                    emit                = 1'b1;
                    emit_res.out_byte   = bval;
                    emit_res.byte_index = r_idx;
                    emit_res.last       = (r_idx == r_last_idx);
                    n_off               = r_off + BITS_W'(nn);
                    n_nbits             = r_nbits - 7'(nn);
                    n_idx               = r_idx + 3'd1;
                    if (r_nbits > 7'(nn)) begin
                        // fetch the window for the next byte
                        ram_re    = 1'b1;
                        fetch_off = r_off + BITS_W'(nn);
                    end else if (r_idx != r_last_idx) begin
                        n_state = S_ZERO;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ZERO: begin
                if (out_free) begin
                    emit                = 1'b1;
                    emit_res.byte_index = r_idx;
                    emit_res.last       = (r_idx == r_last_idx);
                    n_idx               = r_idx + 3'd1;
                    if (r_idx == r_last_idx) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_CCHK: begin
                if (have_bits(r_off, r_size, CHK_W'(1))) begin
                    ram_re  = 1'b1;
                    n_state = S_CFLAG;
                end else begin
                    n_state = S_ERR;
                end
            end
            S_CFLAG: begin
                // flag bits stay consumed even if the value runs out of data
                n_off = off1;
                if (r_cur == 3'd0) begin
                    if (have_bits(off1, r_size, CHK_W'(nib_bits))) begin
                        ram_re    = 1'b1;
                        fetch_off = off1;
                        n_nbits   = nib_bits;
                        n_right   = 1'b1;
                        n_idx     = 3'd0;
                        n_state   = S_RD;
                    end else begin
                        n_state = S_ERR;
                    end
                end else if (shifted[15]) begin
                    n_cur   = r_cur - 3'd1;
                    n_state = S_CCHK;
                end else begin
                    if (have_bits(off1, r_size, CHK_W'(raw_bits))) begin
                        ram_re    = 1'b1;
                        fetch_off = off1;
                        n_nbits   = raw_bits;
                        n_right   = 1'b0;
                        n_idx     = 3'd0;
                        n_state   = S_RD;
                    end else begin
                        n_state = S_ERR;
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    emit            = 1'b1;
                    emit_res.status = ST_NOBITS;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_off       <= '0;
            r_size      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_off   <= n_off;
            r_size  <= n_size;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_nbits    <= n_nbits;
        r_right    <= n_right;
        r_idx      <= n_idx;
        r_last_idx <= n_last_idx;
        r_cur      <= n_cur;
        if (emit) begin
            r_out <= emit_res;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_res   = r_out;

    a_off_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_off <= r_size)
        else $error("read offset beyond loaded data");

    a_size_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_size[2:0] == 3'd0)
        else $error("loaded size not a whole number of bytes");

    a_rd_has_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_nbits != 7'd0))
        else $error("byte read state with no bits left");

    a_rd_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD && out_free) |-> have_bits(r_off, r_size, CHK_W'(nn)))
        else $error("bits read beyond loaded data");

    a_size_only_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_size != $past(r_size)) |-> $past(ram_we))
        else $error("size changed without a load");

endmodule

### rtl/msb_first_bit_reader.sv
// msb-first bit reader top level: front end, command queue and back end
// load, skip, rejected and ignored requests give their result through the command queue and the
//   result register; a flag or a read byte also passes the registered buffer ram read, and a
//   compressed read reads each flag bit (S_CCHK, S_CFLAG) before its first byte or its error result
// reads give one byte per cycle from the dual-read buffer ram while the result output is not
//   stalled; a compressed read first checks its flag bits one at a time
// reset: synchronous, active low; clears offset, size, queue and result valid;
//   buffer contents are not cleared and are only read below the loaded size
module msb_first_bit_reader import mbr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // data_byte[7:0], bit_count[14:8], align_right[15], byte_count[24:16], zero pad
    input  logic [31:0] s_axis_tdata,
    // req_type[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_byte[7:0], byte_index[10:8], flag_value[11], zero pad
    output logic [15:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    logic    queue_full;
    logic    push;
    t_cmd    front_cmd;
    logic    q_valid;
    t_cmd    q_cmd;
    logic    q_pop;
    t_result res;

    mbr_front u_front (
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_req_type    (s_axis_tuser),
        .i_data_byte   (s_axis_tdata[7:0]),
        .i_bit_count   (s_axis_tdata[14:8]),
        .i_align_right (s_axis_tdata[15]),
        .i_byte_count  (s_axis_tdata[24:16]),
        .i_queue_full  (queue_full),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    mbr_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    mbr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_m_res   (res)
    );

    assign m_axis_tdata = {4'b0000, res.flag_value, res.byte_index, res.out_byte};
    assign m_axis_tuser = res.status;
    assign m_axis_tlast = res.last;

endmodule
